FILE: rtl/srg2d_pkg.sv
// Shared constants and types for the seeded region growing block.
`timescale 1ns / 1ps
package srg2d_pkg;
	localparam int ROW_W = 6;
	localparam int COL_W = 6;
	localparam int POS_W = ROW_W + COL_W;
	localparam int PIX_TOTAL = 1 << POS_W;
	localparam int FR_DEPTH = 4096;
	localparam int FR_AW = 12;
	localparam int CNT_W = 13;
	localparam int SUM_W = 20;
	localparam int DIST_W = 21;
	localparam logic [6:0] MAX_ROWS = 7'd64;
	localparam logic [6:0] MAX_COLS = 7'd64;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_GROW  = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		CFG_ROWS = 2'd0,
		CFG_COLS = 2'd1,
		CFG_THR  = 2'd2,
		CFG_NONE = 2'd3
	} cfg_idx_t;

	localparam logic [1:0] LB_FREE = 2'd0;
	localparam logic [1:0] LB_QUEUED = 2'd1;
	localparam logic [1:0] LB_REGION = 2'd2;
endpackage

FILE: rtl/seeded_region_growing_2d.sv
// Seeded region growing: pixel store, label store, frontier list and sequencer.
// Write, off-image and opcode 3: result the cycle after accept; no new op until it is taken.
// Read mark: the label is read in S_RDMARK and the result registered; no new op until taken.
// Grow: setup, a label clearing sweep over all 4096 labels, seed states, then per step
// a neighbour read (skipped off the image) and check, a frontier scan, then a removal.
// arst_n clears state and counters, resets config to defaults; marks read 0 until a grow.
`timescale 1ns / 1ps
module seeded_region_growing_2d (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    opcode,
	input  logic [srg2d_pkg::ROW_W-1:0]   row,
	input  logic [srg2d_pkg::COL_W-1:0]   col,
	input  logic [7:0]                    pixel,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          in_region,
	output logic [srg2d_pkg::CNT_W-1:0]   region_count,
	output logic                          bad_position,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [7:0]                    cfg_data
);
	import srg2d_pkg::*;

	typedef enum logic [14:0] {
		S_IDLE   = 15'b000000000000001,
		S_RDMARK = 15'b000000000000010,
		S_CLEAR  = 15'b000000000000100,
		S_NB     = 15'b000000000001000,
		S_NBRD   = 15'b000000000010000,
		S_NBCHK  = 15'b000000000100000,
		S_SCANRD = 15'b000000001000000,
		S_SCANMU = 15'b000000010000000,
		S_SCANCP = 15'b000000100000000,
		S_PICK   = 15'b000001000000000,
		S_PICKRD = 15'b000010000000000,
		S_LASTRD = 15'b000100000000000,
		S_MOVE   = 15'b001000000000000,
		S_DONE   = 15'b010000000000000,
		S_SEED   = 15'b100000000000000
	} state_t;

	state_t state_q;

	logic [6:0] rows_cfg_q, cols_cfg_q;
	logic [7:0] thr_q;

	logic [7:0] pix_mem [PIX_TOTAL];
	logic [1:0] lab_mem [PIX_TOTAL];
	logic [POS_W-1:0] frp_mem [FR_DEPTH];
	logic [7:0] frv_mem [FR_DEPTH];

	logic [7:0] pix_rd_q;
	logic [1:0] lab_rd_q;
	logic [POS_W-1:0] frp_rd_q;
	logic [7:0] frv_rd_q;

	logic [CNT_W-1:0] fcount_q, n_q, marked_q, total_q, k_q;
	logic [SUM_W-1:0] sum_q;
	logic [POS_W-1:0] cur_q, nb_pos_q, clr_q;
	logic [1:0] dir_q;
	logic [FR_AW-1:0] best_q;
	logic [DIST_W-1:0] best_dist_q, dist_q;
	logic [6:0] rows_q, cols_q;
	logic go_q;
	logic nb_ok_q;
	logic grown_q;

	logic out_valid_q, in_region_q, bad_q;

	logic [6:0] rows_c, cols_c;
	always_comb begin
		rows_c = (rows_cfg_q == 7'd0) ? 7'd1 : (rows_cfg_q > MAX_ROWS ? MAX_ROWS : rows_cfg_q);
		cols_c = (cols_cfg_q == 7'd0) ? 7'd1 : (cols_cfg_q > MAX_COLS ? MAX_COLS : cols_cfg_q);
	end

	logic accept;
	logic bad_c;
	logic [POS_W-1:0] in_pos;
	assign in_stall = (state_q != S_IDLE) || out_valid_q;
	assign accept = in_valid && !in_stall;
	assign bad_c = ({1'b0, row} >= rows_c) || ({1'b0, col} >= cols_c);
	assign in_pos = {row, col};

	// neighbour position
	logic [ROW_W-1:0] cr;
	logic [COL_W-1:0] cc;
	logic nb_ok;
	logic [ROW_W:0] nr;
	logic [COL_W:0] nc;
	always_comb begin
		cr = cur_q[POS_W-1:COL_W];
		cc = cur_q[COL_W-1:0];
		nr = {1'b0, cr};
		nc = {1'b0, cc};
		nb_ok = 1'b1;
		case (dir_q)
			2'd0: begin
				nb_ok = (cr != '0);
				nr = {1'b0, cr} - 7'd1;
			end
			2'd1: begin
				nr = {1'b0, cr} + 7'd1;
				nb_ok = (nr < rows_q);
			end
			2'd2: begin
				nb_ok = (cc != '0);
				nc = {1'b0, cc} - 7'd1;
			end
			default: begin
				nc = {1'b0, cc} + 7'd1;
				nb_ok = (nc < cols_q);
			end
		endcase
	end

	// distance unit: |v*n - sum|
	logic [DIST_W-1:0] prod_c;
	logic [DIST_W-1:0] sum_ext;
	assign prod_c = DIST_W'(frv_rd_q) * DIST_W'(n_q);
	assign sum_ext = {1'b0, sum_q};

	logic [FR_AW-1:0] k_idx;
	assign k_idx = k_q[FR_AW-1:0];
	logic [CNT_W-1:0] last_c;
	assign last_c = fcount_q - 13'd1;

	// memories
	logic pix_we, lab_we, fr_we;
	logic [POS_W-1:0] pix_ra, lab_wa, lab_ra;
	logic [1:0] lab_wd;
	logic [FR_AW-1:0] fr_wa, fr_ra;
	logic [POS_W-1:0] frp_wd;
	logic [7:0] frv_wd;

	always_comb begin
		pix_we = accept && !bad_c && (opcode == OP_WRITE);
		pix_ra = in_pos;
		lab_ra = in_pos;
		lab_we = 1'b0;
		lab_wa = clr_q;
		lab_wd = LB_FREE;
		fr_we = 1'b0;
		fr_wa = fcount_q[FR_AW-1:0];
		fr_ra = k_idx;
		frp_wd = nb_pos_q;
		frv_wd = pix_rd_q;
		case (state_q)
			S_CLEAR: lab_we = 1'b1;
			S_SEED: pix_ra = cur_q;
			S_NB, S_NBRD: begin
				pix_ra = {nr[ROW_W-1:0], nc[COL_W-1:0]};
				lab_ra = {nr[ROW_W-1:0], nc[COL_W-1:0]};
			end
			S_NBCHK: begin
				if (nb_ok_q && lab_rd_q == LB_FREE && fcount_q < CNT_W'(FR_DEPTH)) begin
					lab_we = 1'b1;
					lab_wa = nb_pos_q;
					lab_wd = LB_QUEUED;
					fr_we = 1'b1;
				end
			end
			S_PICK: begin
				lab_we = 1'b1;
				lab_wa = cur_q;
				lab_wd = LB_REGION;
				fr_ra = best_q;
			end
			S_PICKRD, S_LASTRD: fr_ra = last_c[FR_AW-1:0];
			S_MOVE: begin
				fr_we = 1'b1;
				fr_wa = best_q;
				frp_wd = frp_rd_q;
				frv_wd = frv_rd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pix_we) pix_mem[in_pos] <= pixel;
		pix_rd_q <= pix_mem[pix_ra];
		if (lab_we) lab_mem[lab_wa] <= lab_wd;
		lab_rd_q <= lab_mem[lab_ra];
		if (fr_we) begin
			frp_mem[fr_wa] <= frp_wd;
			frv_mem[fr_wa] <= frv_wd;
		end
		frp_rd_q <= frp_mem[fr_ra];
		frv_rd_q <= frv_mem[fr_ra];
	end

	logic [POS_W-1:0] chosen_q;
	logic [7:0] chosen_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rows_cfg_q <= 7'd64;
			cols_cfg_q <= 7'd64;
			thr_q <= 8'd51;
			out_valid_q <= 1'b0;
			in_region_q <= 1'b0;
			bad_q <= 1'b0;
			marked_q <= '0;
			fcount_q <= '0;
			n_q <= '0;
			sum_q <= '0;
			clr_q <= '0;
			k_q <= '0;
			dir_q <= '0;
			go_q <= 1'b0;
			nb_ok_q <= 1'b0;
			grown_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ROWS: rows_cfg_q <= cfg_data[6:0];
					CFG_COLS: cols_cfg_q <= cfg_data[6:0];
					CFG_THR:  thr_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						bad_q <= bad_c && (opcode != OP_NONE);
						in_region_q <= 1'b0;
						rows_q <= rows_c;
						cols_q <= cols_c;
						total_q <= CNT_W'(rows_c) * CNT_W'(cols_c);
						cur_q <= in_pos;
						if (bad_c || opcode == OP_WRITE || opcode == OP_NONE) begin
							out_valid_q <= 1'b1;
						end else if (opcode == OP_READ) begin
							state_q <= S_RDMARK;
						end else begin
							clr_q <= '0;
							state_q <= S_CLEAR;
						end
					end
				end
				S_RDMARK: begin
					in_region_q <= grown_q && (lab_rd_q == LB_REGION);
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == POS_W'(PIX_TOTAL - 1)) state_q <= S_SEED;
				end
				S_SEED: begin
					// pix_rd_q valid in the next state via cur_q read
					fcount_q <= '0;
					marked_q <= '0;
					n_q <= 13'd1;
					go_q <= (thr_q != 8'd0);
					dir_q <= '0;
					grown_q <= 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					// first cycle here after seed: load sum from seed pixel
					sum_q <= {12'd0, pix_rd_q};
					if (!go_q || total_q <= 13'd1) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else state_q <= S_NB;
				end
				S_NB: begin
					nb_pos_q <= {nr[ROW_W-1:0], nc[COL_W-1:0]};
					nb_ok_q <= nb_ok;
					state_q <= nb_ok ? S_NBRD : S_NBCHK;
				end
				S_NBRD: state_q <= S_NBCHK;
				S_NBCHK: begin
					if (lab_we) fcount_q <= fcount_q + 1'b1;
					dir_q <= dir_q + 1'b1;
					if (dir_q != 2'd3) state_q <= S_NB;
					else if (fcount_q == '0 && !lab_we) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						k_q <= '0;
						state_q <= S_SCANRD;
					end
				end
				S_SCANRD: state_q <= S_SCANMU;
				S_SCANMU: begin
					dist_q <= (prod_c >= sum_ext) ? prod_c - sum_ext : sum_ext - prod_c;
					state_q <= S_SCANCP;
				end
				S_SCANCP: begin
					if (k_q == '0 || dist_q < best_dist_q) begin
						best_dist_q <= dist_q;
						best_q <= k_idx;
					end
					k_q <= k_q + 1'b1;
					state_q <= (k_q + 13'd1 < fcount_q) ? S_SCANRD : S_PICK;
				end
				S_PICK: begin
					marked_q <= marked_q + 1'b1;
					go_q <= best_dist_q < DIST_W'(thr_q) * DIST_W'(n_q);
					state_q <= S_PICKRD;
				end
				S_PICKRD: begin
					chosen_q <= frp_rd_q;
					chosen_v_q <= frv_rd_q;
					state_q <= S_LASTRD;
				end
				S_LASTRD: state_q <= S_MOVE;
				S_MOVE: begin
					n_q <= n_q + 1'b1;
					sum_q <= sum_q + {12'd0, chosen_v_q};
					cur_q <= chosen_q;
					fcount_q <= last_c;
					dir_q <= '0;
					if (!go_q || n_q + 13'd1 >= total_q) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else state_q <= S_NB;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign in_region = in_region_q;
	assign region_count = marked_q;
	assign bad_position = bad_q;
endmodule
